@@ rtl/core/ssvf_pkg.sv @@
// Shared types, widths and helpers for the stereo state-variable filter.
// No dependencies; compiled first.
package ssvf_pkg;

  localparam int unsigned X_W     = 24;   // Q3.20 samples
  localparam int unsigned S_W     = 28;   // Q7.20 integrator states
  localparam int unsigned C_W     = 18;   // Q1.17 coefficients
  localparam int unsigned K_W     = 17;   // Q1.16 damping
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned V3_W    = S_W + 1;
  localparam int unsigned CS_W    = C_W + 1;   // coefficient, signed view
  localparam int unsigned P_W     = 49;        // coefficient products and their sums
  localparam int unsigned V1_W    = P_W - 17;  // 32
  localparam int unsigned V2_W    = V1_W + 1;  // 33
  localparam int unsigned PK_W    = 51;        // damping product and rounding sum
  localparam int unsigned R_W     = PK_W - 16; // 35
  localparam int unsigned FULL_W  = 36;        // pre-saturation width

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd1;

  localparam logic [K_W-1:0]    DAMPING_RESET = 17'd36409;
  localparam logic [MODE_W-1:0] MODE_LP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BP = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HP = 2'd2;

  localparam logic signed [P_W-1:0]  HALF17 = 49'sd65536;
  localparam logic signed [PK_W-1:0] HALF16 = 51'sd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_UPD,
    ST_FIN
  } ssvf_state_t;

  // one strobe per registered step of the lane recursion
  typedef struct packed {
    logic mul;
    logic acc;
    logic upd;
  } ssvf_step_t;

  function automatic logic signed [S_W-1:0] sat_state(input logic signed [FULL_W-1:0] v);
    logic signed [FULL_W-1:0] hi;
    logic signed [FULL_W-1:0] lo;
    hi = FULL_W'((64'sd1 <<< (S_W - 1)) - 64'sd1);
    lo = -hi - FULL_W'(1);
    if (v > hi)      sat_state = hi[S_W-1:0];
    else if (v < lo) sat_state = lo[S_W-1:0];
    else             sat_state = v[S_W-1:0];
  endfunction

  function automatic logic signed [X_W-1:0] sat_sample(input logic signed [FULL_W-1:0] v);
    logic signed [FULL_W-1:0] hi;
    logic signed [FULL_W-1:0] lo;
    hi = FULL_W'((64'sd1 <<< (X_W - 1)) - 64'sd1);
    lo = -hi - FULL_W'(1);
    if (v > hi)      sat_sample = hi[X_W-1:0];
    else if (v < lo) sat_sample = lo[X_W-1:0];
    else             sat_sample = v[X_W-1:0];
  endfunction

endpackage

@@ rtl/core/ssvf_in_if.sv @@
// Input channel: one stereo sample pair plus three coefficients per beat.
// Depends on ssvf_pkg.
interface ssvf_in_if;
  import ssvf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [X_W-1:0]   sample_left;
  logic signed [X_W-1:0]   sample_right;
  logic        [C_W-1:0]   coef_one;
  logic        [C_W-1:0]   coef_two;
  logic        [C_W-1:0]   coef_three;

  modport source (output valid, sample_left, sample_right, coef_one, coef_two, coef_three,
                  input ready);
  modport sink   (input valid, sample_left, sample_right, coef_one, coef_two, coef_three,
                  output ready);
endinterface

@@ rtl/core/ssvf_out_if.sv @@
// Result channel: one filtered stereo pair per beat.
// Depends on ssvf_pkg.
interface ssvf_out_if;
  import ssvf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [X_W-1:0] filtered_left;
  logic signed [X_W-1:0] filtered_right;

  modport source (output valid, filtered_left, filtered_right, input ready);
  modport sink   (input valid, filtered_left, filtered_right, output ready);
endinterface

@@ rtl/core/ssvf_cfg_if.sv @@
// Configuration write channel: register index and data per beat.
// Depends on ssvf_pkg.
interface ssvf_cfg_if;
  import ssvf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/stereo_state_variable_filter_top.sv @@
// Stereo two-pole state-variable filter, top level. Depends on ssvf_pkg,
// the three channel interfaces and ssvf_lane.
//
// One stereo pair plus its coefficients is taken per input beat and one
// filtered pair comes back per result beat. Both channels run in their own
// lane at once; each item walks four steps: coefficient products, the
// v1/v2 sums, the saturated state update with the damping product, and
// output selection into the result register. A new item is taken only
// while idle or as the last result is loaded, since the lane states that
// each item updates feed the next one. A stalled result holds the block
// in its last step. The configuration port is always ready; write it only
// while no item is in flight.
module stereo_state_variable_filter_top #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  ssvf_in_if.sink    in_ch,
  ssvf_out_if.source out_ch,
  ssvf_cfg_if.sink   cfg_ch
);
  import ssvf_pkg::*;

  localparam int unsigned LANES = (CHANNELS < 2) ? CHANNELS : 2;

  ssvf_state_t state_r, state_nxt;
  ssvf_step_t  step;
  logic        in_acc;
  logic        out_load;
  logic        out_free;

  logic [K_W-1:0]    damping_r;
  logic [MODE_W-1:0] mode_r;

  logic signed [X_W-1:0]  x_r [LANES];
  logic signed [CS_W-1:0] c1_r, c2_r, c3_r;
  logic signed [X_W-1:0]  y   [LANES];

  logic                  out_valid_r;
  logic signed [X_W-1:0] left_r, right_r;
  logic signed [X_W-1:0] right_y;

  // configuration
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damping_r <= DAMPING_RESET;
      mode_r    <= MODE_LP;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_DAMPING) damping_r <= cfg_ch.data[K_W-1:0];
      if (cfg_ch.index == CFG_MODE)    mode_r    <= cfg_ch.data[MODE_W-1:0];
    end
  end

  // sequencer
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) state_nxt = in_acc ? ST_MUL : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    step        = '0;
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      ST_MUL:  step.mul = 1'b1;
      ST_ACC:  step.acc = 1'b1;
      ST_UPD:  step.upd = 1'b1;
      ST_FIN: begin
        out_load    = out_free;
        in_ch.ready = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r[0] <= in_ch.sample_left;
      if (LANES > 1) x_r[LANES-1] <= in_ch.sample_right;
      c1_r <= $signed({1'b0, in_ch.coef_one});
      c2_r <= $signed({1'b0, in_ch.coef_two});
      c3_r <= $signed({1'b0, in_ch.coef_three});
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    ssvf_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (step),
      .x     (x_r[g]),
      .c1    (c1_r),
      .c2    (c2_r),
      .c3    (c3_r),
      .k     ($signed({2'b00, damping_r})),
      .mode  (mode_r),
      .y     (y[g])
    );
  end

  // merge lanes into the result beat; a missing right lane reads zero
  if (LANES > 1) begin : g_right
    assign right_y = y[LANES-1];
  end else begin : g_mono
    assign right_y = '0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      left_r  <= y[0];
      right_r <= right_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)        out_valid_r <= 1'b0;
    else if (out_load) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_left  = left_r;
  assign out_ch.filtered_right = right_r;

  // checks
  a_accept_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (state_r == ST_IDLE || state_r == ST_FIN))
    else $error("input beat taken mid-item");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_MUL))
    else $error("accepted item did not start the multiply step");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the final step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !out_load)
    else $error("pending result overwritten");

endmodule

@@ rtl/core/ssvf_lane.sv @@
// One channel of the filter: two integrator states and the four-step
// multiply/accumulate/update/output chain. Depends on ssvf_pkg.
module ssvf_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ssvf_pkg::ssvf_step_t           step,
  input  logic signed [ssvf_pkg::X_W-1:0]  x,
  input  logic signed [ssvf_pkg::CS_W-1:0] c1,
  input  logic signed [ssvf_pkg::CS_W-1:0] c2,
  input  logic signed [ssvf_pkg::CS_W-1:0] c3,
  input  logic signed [ssvf_pkg::CS_W-1:0] k,
  input  logic        [ssvf_pkg::MODE_W-1:0] mode,
  output logic signed [ssvf_pkg::X_W-1:0]  y
);
  import ssvf_pkg::*;

  logic signed [S_W-1:0]  s1_r, s2_r;
  logic signed [P_W-1:0]  pa_r, pb_r, pc_r, pd_r;
  logic signed [V1_W-1:0] v1_r;
  logic signed [V2_W-1:0] v2_r;
  logic signed [PK_W-1:0] pk_r;

  logic signed [V3_W-1:0]   v3;
  logic signed [P_W-1:0]    sum1, sum2;
  logic signed [FULL_W-1:0] s1_full, s2_full;
  logic signed [PK_W-1:0]   pk_rnd;
  logic signed [R_W-1:0]    kv1;
  logic signed [FULL_W-1:0] y_full;

  assign v3 = V3_W'(x) - V3_W'(s2_r);

  // round half up, floor shift by taking the upper bits
  assign sum1 = pa_r + pb_r + HALF17;
  assign sum2 = pc_r + pd_r + HALF17;

  assign s1_full = (FULL_W'(v1_r) <<< 1) - FULL_W'(s1_r);
  assign s2_full = (FULL_W'(v2_r) <<< 1) - FULL_W'(s2_r);

  assign pk_rnd = pk_r + HALF16;
  assign kv1    = pk_rnd[PK_W-1:16];

  always_comb begin
    unique case (mode)
      MODE_LP: y_full = FULL_W'(v2_r);
      MODE_BP: y_full = FULL_W'(v1_r);
      default: y_full = FULL_W'(x) - FULL_W'(kv1) - FULL_W'(v2_r);
    endcase
  end

  assign y = sat_sample(y_full);

  always_ff @(posedge clk) begin
    if (step.mul) begin
      pa_r <= P_W'(c1 * s1_r);
      pb_r <= P_W'(c2 * v3);
      pc_r <= P_W'(c2 * s1_r);
      pd_r <= P_W'(c3 * v3);
    end
    if (step.acc) begin
      v1_r <= sum1[P_W-1:17];
      v2_r <= V2_W'(s2_r) + V2_W'($signed(sum2[P_W-1:17]));
    end
    if (step.upd) begin
      pk_r <= PK_W'(k * v1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
    end else if (step.upd) begin
      s1_r <= sat_state(s1_full);
      s2_r <= sat_state(s2_full);
    end
  end

endmodule
